[src/mwlzcr_pkg.sv]
// Shared types and constants for the mic window level / zero-crossing meter.
// No dependencies; used by every module of the block by scoped names.
`timescale 1ns / 1ps

package mwlzcr_pkg;

    localparam int WORD_W  = 32;
    localparam int CROSS_W = 8;
    localparam int SCALE_W = 13;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_SHIFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DC_SHIFT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZCR_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_DIVISOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZCR_SCALE     = 3'd4;

    // hysteresis sign tracker codes
    localparam logic [1:0] SIGN_NONE = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd2;

    localparam logic [7:0] SAT_MAX = 8'hFF;

    typedef struct packed {
        logic [4:0]  input_shift;
        logic [3:0]  dc_shift;
        logic [15:0] zcr_threshold;
    } lane_cfg_t;

    typedef struct packed {
        logic accept;   // new frame word enters the lane
        logic reload;   // window closed: restart from committed DC
    } lane_ctrl_t;

endpackage

[src/mic_window_level_zcr_meter.sv]
// Top level of the mic window meter: config registers, frame counter, the
// merge stage over the two lanes and the output register.
// Depends on mwlzcr_pkg, mwlzcr_lane and mwlzcr_div.
//
//   channel  | signals                                        | dir
//   ---------+------------------------------------------------+-----
//   frames   | in_valid, in_stall, left_word, right_word,     | in
//            | last_frame                                     |
//   results  | out_valid, out_stall, level, zero_cross_rate,  | out
//            | left_chosen                                    |
//   config   | cfg_wr_en, cfg_index, cfg_data                 | in
//
// Within a window one frame is taken every cycle; the lanes are two stages deep.
// Closing a window holds off frames through lane drain, merge, divider start,
// the 8 quotient bits of the serial dividers, and the output load (longer
// if the previous result has not been taken). Only one result waits at a time.
// Reset is asynchronous; no clearing pass is needed after it.
`timescale 1ns / 1ps

module mic_window_level_zcr_meter #(
    parameter int MAX_WINDOW_FRAMES = 128
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_stall,
    input  logic signed [mwlzcr_pkg::WORD_W-1:0]       left_word,
    input  logic signed [mwlzcr_pkg::WORD_W-1:0]       right_word,
    input  logic                                       last_frame,
    output logic                                       out_valid,
    input  logic                                       out_stall,
    output logic [7:0]                                 level,
    output logic [7:0]                                 zero_cross_rate,
    output logic                                       left_chosen,
    input  logic                                       cfg_wr_en,
    input  logic [mwlzcr_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [mwlzcr_pkg::CFG_W-1:0]               cfg_data
);

    localparam int FC_W     = $clog2(MAX_WINDOW_FRAMES + 1);
    localparam int ENERGY_W = mwlzcr_pkg::WORD_W + FC_W;
    localparam int LDEN_W   = FC_W + 8;
    localparam int ZNUM_W   = mwlzcr_pkg::CROSS_W + mwlzcr_pkg::SCALE_W;
    localparam logic [FC_W-1:0] LAST_COUNT = FC_W'(MAX_WINDOW_FRAMES - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DRAIN  = 3'd1;
    localparam logic [2:0] ST_MERGE  = 3'd2;
    localparam logic [2:0] ST_LAUNCH = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;

    logic [2:0]  state_reg;
    logic [2:0]  state_next;

    logic [4:0]  input_shift_reg;
    logic [3:0]  dc_shift_reg;
    logic [15:0] zcr_threshold_reg;
    logic [7:0]  level_divisor_reg;
    logic [12:0] zcr_scale_reg;

    logic [FC_W-1:0] frame_count_reg;

    mwlzcr_pkg::lane_cfg_t  lane_cfg;
    mwlzcr_pkg::lane_ctrl_t lane_ctrl;

    logic [ENERGY_W-1:0]                  energy_l, energy_r;
    logic signed [mwlzcr_pkg::WORD_W-1:0] dc_l, dc_r, win_dc;
    logic [mwlzcr_pkg::CROSS_W-1:0]       cross_l, cross_r;

    logic              accept;
    logic              close;
    logic              left_win;
    logic [ZNUM_W-1:0] zprod_l, zprod_r;

    logic [ENERGY_W-1:0] lvl_num_reg;
    logic [LDEN_W-1:0]   lvl_den_reg;
    logic [ZNUM_W-1:0]   zcr_num_reg;
    logic [FC_W-1:0]     zcr_den_reg;
    logic                left_win_reg;

    logic       div_start;
    logic       lvl_busy, zcr_busy;
    logic [7:0] lvl_quot, zcr_quot;
    logic       out_free;
    logic       out_load;

    logic       out_valid_reg;
    logic [7:0] level_reg;
    logic [7:0] zcr_reg;
    logic       left_chosen_reg;

    assign accept   = in_valid && !in_stall;
    assign close    = last_frame || (frame_count_reg == LAST_COUNT);
    assign in_stall = (state_reg != ST_IDLE);

    assign lane_cfg.input_shift   = input_shift_reg;
    assign lane_cfg.dc_shift      = dc_shift_reg;
    assign lane_cfg.zcr_threshold = zcr_threshold_reg;
    assign lane_ctrl.accept       = accept;
    assign lane_ctrl.reload       = (state_reg == ST_MERGE);

    // louder slot wins, left on a tie
    assign left_win = (energy_l >= energy_r);
    assign win_dc   = left_win ? dc_l : dc_r;
    assign zprod_l  = ZNUM_W'(cross_l) * ZNUM_W'(zcr_scale_reg);
    assign zprod_r  = ZNUM_W'(cross_r) * ZNUM_W'(zcr_scale_reg);

    assign div_start = (state_reg == ST_LAUNCH);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = (state_reg == ST_DIV) && !lvl_busy && !zcr_busy && out_free;

    mwlzcr_lane #(.ENERGY_W(ENERGY_W)) u_lane_l (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (lane_ctrl),
        .cfg       (lane_cfg),
        .word      (left_word),
        .reload_dc (win_dc),
        .energy    (energy_l),
        .dc        (dc_l),
        .crossings (cross_l)
    );

    mwlzcr_lane #(.ENERGY_W(ENERGY_W)) u_lane_r (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (lane_ctrl),
        .cfg       (lane_cfg),
        .word      (right_word),
        .reload_dc (win_dc),
        .energy    (energy_r),
        .dc        (dc_r),
        .crossings (cross_r)
    );

    // (energy / frames) / divisor == energy / (frames * divisor)
    mwlzcr_div #(.NUM_W(ENERGY_W), .DEN_W(LDEN_W)) u_div_level (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (lvl_num_reg),
        .den   (lvl_den_reg),
        .busy  (lvl_busy),
        .quot  (lvl_quot)
    );

    mwlzcr_div #(.NUM_W(ZNUM_W), .DEN_W(FC_W)) u_div_zcr (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (zcr_num_reg),
        .den   (zcr_den_reg),
        .busy  (zcr_busy),
        .quot  (zcr_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept && close)
                    state_next = ST_DRAIN;
            ST_DRAIN:  state_next = ST_MERGE;
            ST_MERGE:  state_next = ST_LAUNCH;
            ST_LAUNCH: state_next = ST_DIV;
            ST_DIV:
                if (out_load)
                    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            input_shift_reg   <= 5'd11;
            dc_shift_reg      <= 4'd7;
            zcr_threshold_reg <= 16'd150;
            level_divisor_reg <= 8'd40;
            zcr_scale_reg     <= 13'd512;
            frame_count_reg   <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    mwlzcr_pkg::CFG_INPUT_SHIFT:   input_shift_reg   <= cfg_data[4:0];
                    mwlzcr_pkg::CFG_DC_SHIFT:      dc_shift_reg      <= cfg_data[3:0];
                    mwlzcr_pkg::CFG_ZCR_THRESHOLD: zcr_threshold_reg <= cfg_data;
                    mwlzcr_pkg::CFG_LEVEL_DIVISOR: level_divisor_reg <= cfg_data[7:0];
                    mwlzcr_pkg::CFG_ZCR_SCALE:     zcr_scale_reg     <= cfg_data[12:0];
                    default: ;
                endcase
            end

            if (state_reg == ST_MERGE)
                frame_count_reg <= '0;
            else if (accept)
                frame_count_reg <= frame_count_reg + FC_W'(1);

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // merge stage operands, captured after the last frame has left the lanes
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MERGE)
        begin
            lvl_num_reg  <= left_win ? energy_l : energy_r;
            lvl_den_reg  <= LDEN_W'(frame_count_reg) * LDEN_W'(level_divisor_reg);
            zcr_num_reg  <= left_win ? zprod_l : zprod_r;
            zcr_den_reg  <= frame_count_reg;
            left_win_reg <= left_win;
        end
        if (out_load)
        begin
            level_reg       <= lvl_quot;
            zcr_reg         <= zcr_quot;
            left_chosen_reg <= left_win_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign level           = level_reg;
    assign zero_cross_rate = zcr_reg;
    assign left_chosen     = left_chosen_reg;

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        frame_count_reg <= FC_W'(MAX_WINDOW_FRAMES))
        else $error("frame count beyond window cap");

    a_close_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && close) |=> (state_reg == ST_DRAIN))
        else $error("window close did not start the drain");

    a_result_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DIV))
        else $error("result raised outside the divide phase");

    a_div_busy_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (lvl_busy || zcr_busy) |-> (state_reg == ST_DIV))
        else $error("divider busy outside the divide phase");

    a_cross_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |->
            (FC_W'(cross_l) <= frame_count_reg || cross_l <= 8'(MAX_WINDOW_FRAMES)))
        else $error("left lane crossings exceed frames");

endmodule

[src/mwlzcr_lane.sv]
// One slot lane: input shift, magnitude sum, EMA DC removal and hysteresis
// zero-crossing counter. Two stages. Depends on mwlzcr_pkg.
`timescale 1ns / 1ps

module mwlzcr_lane #(
    parameter int ENERGY_W = 40
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mwlzcr_pkg::lane_ctrl_t              ctrl,
    input  mwlzcr_pkg::lane_cfg_t               cfg,
    input  logic signed [mwlzcr_pkg::WORD_W-1:0] word,
    input  logic signed [mwlzcr_pkg::WORD_W-1:0] reload_dc,
    output logic [ENERGY_W-1:0]                 energy,
    output logic signed [mwlzcr_pkg::WORD_W-1:0] dc,
    output logic [mwlzcr_pkg::CROSS_W-1:0]      crossings
);

    localparam int W = mwlzcr_pkg::WORD_W;

    logic signed [W-1:0]        x_reg;
    logic                       x_valid_reg;
    logic signed [W-1:0]        dc_reg;
    logic signed [W-1:0]        dc_next;
    logic [1:0]                 sign_reg;
    logic [1:0]                 sign_next;
    logic [mwlzcr_pkg::CROSS_W-1:0] cross_reg;
    logic [ENERGY_W-1:0]        energy_reg;
    logic [ENERGY_W-1:0]        energy_next;

    logic [W-1:0]               mag;
    logic signed [W:0]          y;
    logic signed [W:0]          y_shr;
    logic signed [W:0]          dc_sum;
    logic signed [W+1:0]        y_ext;
    logic signed [W+1:0]        thr_p;
    logic                       crossed;

    always_comb
    begin
        // magnitude of the most negative word is 2^31 as unsigned
        mag         = x_reg[W-1] ? (~x_reg + W'(1)) : x_reg;
        energy_next = energy_reg + ENERGY_W'(mag);

        y      = $signed({x_reg[W-1], x_reg}) - $signed({dc_reg[W-1], dc_reg});
        y_shr  = y >>> cfg.dc_shift;
        dc_sum = $signed({dc_reg[W-1], dc_reg}) + y_shr;
        // DC stays between its old value and x, so it fits the word width
        dc_next = dc_sum[W-1:0];

        y_ext = {y[W], y};
        thr_p = $signed({{(W+2-16){1'b0}}, cfg.zcr_threshold});
        if (y_ext > thr_p)
            sign_next = mwlzcr_pkg::SIGN_POS;
        else if (y_ext < -thr_p)
            sign_next = mwlzcr_pkg::SIGN_NEG;
        else
            sign_next = sign_reg;

        crossed = (sign_reg != mwlzcr_pkg::SIGN_NONE) && (sign_next != sign_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg <= 1'b0;
            dc_reg      <= '0;
            sign_reg    <= mwlzcr_pkg::SIGN_NONE;
            cross_reg   <= '0;
            energy_reg  <= '0;
        end
        else
        begin
            x_valid_reg <= ctrl.accept;
            if (ctrl.reload)
            begin
                dc_reg     <= reload_dc;
                sign_reg   <= mwlzcr_pkg::SIGN_NONE;
                cross_reg  <= '0;
                energy_reg <= '0;
            end
            else if (x_valid_reg)
            begin
                dc_reg     <= dc_next;
                sign_reg   <= sign_next;
                energy_reg <= energy_next;
                if (crossed && cross_reg != mwlzcr_pkg::SAT_MAX)
                    cross_reg <= cross_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
            x_reg <= word >>> cfg.input_shift;
    end

    assign energy    = energy_reg;
    assign dc        = dc_reg;
    assign crossings = cross_reg;

endmodule

[src/mwlzcr_div.sv]
// Restoring divider giving an 8-bit quotient saturated at 255, one bit a cycle.
// A zero divisor also saturates. Depends on mwlzcr_pkg.
`timescale 1ns / 1ps

module mwlzcr_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [7:0]       quot
);

    localparam int WW = (NUM_W > DEN_W + 8) ? NUM_W : DEN_W + 8;

    logic [WW-1:0]    rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [2:0]       bit_reg;
    logic [7:0]       quot_reg;
    logic             busy_reg;

    logic [WW-1:0]    num_w;
    logic [WW-1:0]    den_top;
    logic [WW-1:0]    trial;
    logic             sat;

    always_comb
    begin
        num_w   = WW'(num);
        den_top = WW'(den) << 8;
        sat     = (den == '0) || (num_w >= den_top);
        trial   = WW'(den_reg) << bit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (start)
            busy_reg <= !sat;
        else if (busy_reg && bit_reg == 3'd0)
            busy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num_w;
            den_reg  <= den;
            bit_reg  <= 3'd7;
            quot_reg <= sat ? mwlzcr_pkg::SAT_MAX : 8'd0;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg           <= rem_reg - trial;
                quot_reg[bit_reg] <= 1'b1;
            end
            bit_reg <= bit_reg - 3'd1;
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule
